@@ rtl/wn_pkg.sv @@
// ----------------------------------------------------------------------------
// wn_pkg: shared types and constants for the winding-number unit
// Request opcodes, sequencer states, edge-unit control and output limits.
// ----------------------------------------------------------------------------
`default_nettype none

package wn_pkg;

    localparam int OPCODE_W    = 2;
    localparam int WINDING_W   = 8;
    localparam int WINDING_MAX = 64;
    // register stages in the edge unit between an edge issue and the updated sum
    localparam int PIPE_DEPTH  = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_CLOSE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic issue;   // evaluate one edge this cycle
        logic clear;   // zero the running winding sum
    } t_edge_ctl;

endpackage

`default_nettype wire

@@ rtl/wn_cell.sv @@
// ----------------------------------------------------------------------------
// wn_cell: one vertex slot of the polygon ring
// Holds one vertex and takes its neighbor's vertex whenever the ring shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module wn_cell #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_shift,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    output logic      [COORD_BITS-1:0] o_x,
    output logic      [COORD_BITS-1:0] o_y
);

    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

@@ rtl/wn_edge_unit.sv @@
// ----------------------------------------------------------------------------
// wn_edge_unit: per-edge crossing test and winding accumulator
// Three stages: offsets from the point, two products, cross sign and sum.
// ----------------------------------------------------------------------------
`default_nettype none

module wn_edge_unit #(
    parameter int COORD_BITS = 16,
    parameter int ACC_W      = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire wn_pkg::t_edge_ctl        i_ctl,
    input  wire logic [COORD_BITS-1:0]    i_ax,
    input  wire logic [COORD_BITS-1:0]    i_ay,
    input  wire logic [COORD_BITS-1:0]    i_bx,
    input  wire logic [COORD_BITS-1:0]    i_by,
    input  wire logic [COORD_BITS-1:0]    i_px,
    input  wire logic [COORD_BITS-1:0]    i_py,
    output logic signed [ACC_W-1:0]       o_wn
);

    localparam int D_W = COORD_BITS + 1;
    localparam int P_W = 2 * D_W;

    logic signed [D_W-1:0] d_ax, d_ay, d_bx, d_by;
    logic signed [D_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic                  r_v1, r_v2;
    logic signed [P_W-1:0] r_m1, r_m2;
    logic                  r_up2, r_dn2;   // crossing direction flags, stage 2
    logic signed [P_W:0]   d_cross;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    // stage 1: offsets relative to the query point
    assign d_ax = $signed({i_ax[COORD_BITS-1], i_ax}) - $signed({i_px[COORD_BITS-1], i_px});
    assign d_ay = $signed({i_ay[COORD_BITS-1], i_ay}) - $signed({i_py[COORD_BITS-1], i_py});
    assign d_bx = $signed({i_bx[COORD_BITS-1], i_bx}) - $signed({i_px[COORD_BITS-1], i_px});
    assign d_by = $signed({i_by[COORD_BITS-1], i_by}) - $signed({i_py[COORD_BITS-1], i_py});

    always_ff @(posedge i_clk) begin
        r_ax <= d_ax;
        r_ay <= d_ay;
        r_bx <= d_bx;
        r_by <= d_by;
        r_m1 <= r_ax * r_by;
        r_m2 <= r_ay * r_bx;
        // upward: a at or below the point, b strictly above
        r_up2 <= (r_ay <= $signed({D_W{1'b0}})) && (r_by > $signed({D_W{1'b0}}));
        // downward: a strictly above, b at or below
        r_dn2 <= (r_ay > $signed({D_W{1'b0}})) && (r_by <= $signed({D_W{1'b0}}));
    end

    // stage 3: exact cross product sign, then accumulate
    assign d_cross = $signed({r_m1[P_W-1], r_m1}) - $signed({r_m2[P_W-1], r_m2});

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (r_v2) begin
            if (r_up2 && (d_cross > $signed({(P_W+1){1'b0}}))) begin
                n_acc = r_acc + ACC_W'(1);
            end else if (r_dn2 && (d_cross < $signed({(P_W+1){1'b0}}))) begin
                n_acc = r_acc - ACC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1  <= i_ctl.issue;
            r_v2  <= r_v1;
            r_acc <= n_acc;
        end
    end

    assign o_wn = r_acc;

endmodule

`default_nettype wire

@@ rtl/winding_number_point_in_polygon_unit.sv @@
// ----------------------------------------------------------------------------
// winding_number_point_in_polygon_unit: polygon store and winding-number test
// Clear and append requests leave busy low. A query request raises busy
// while the vertex ring makes one full turn (one vertex per cycle), the
// closing edge is issued and the 3-stage edge unit drains; its result then
// strobes on o_valid with busy already low, so the next request is taken
// in that same cycle. The receiver cannot stall. Synchronous active-low
// reset clears the vertex count and control; vertex cells are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module winding_number_point_in_polygon_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [wn_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic signed [15:0]           i_coord_x,
    input  wire logic signed [15:0]           i_coord_y,
    output logic                              o_valid,
    output logic                              o_inside_res,
    output logic signed [wn_pkg::WINDING_W-1:0] o_winding
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int ACC_W = CNT_W + 1;            // |winding| <= MAX_VERTICES
    localparam int SAT_W = ACC_W + wn_pkg::WINDING_W;
    localparam logic [CNT_W-1:0] NV = CNT_W'(MAX_VERTICES);

    // ------------------------------------------------------------------
    // Coordinate intake: low COORD_BITS bits as two's complement. Above
    // 16 bits the port value is zero-extended, so its sign is not carried.
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] d_cx, d_cy;

    generate
        if (COORD_BITS <= 16) begin : g_narrow
            assign d_cx = i_coord_x[COORD_BITS-1:0];
            assign d_cy = i_coord_y[COORD_BITS-1:0];
        end else begin : g_wide
            assign d_cx = {{(COORD_BITS-16){1'b0}}, i_coord_x};
            assign d_cy = {{(COORD_BITS-16){1'b0}}, i_coord_y};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    wn_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_step, n_step;
    logic [1:0]       r_drain, n_drain;
    logic             r_valid, n_valid;

    logic [COORD_BITS-1:0] r_px, r_py;
    logic [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic [COORD_BITS-1:0] r_first_x, r_first_y;
    logic                  r_inside;
    logic signed [wn_pkg::WINDING_W-1:0] r_winding;

    logic accept;
    logic do_append;
    logic ring_shift;
    wn_pkg::t_edge_ctl edge_ctl;
    logic [CNT_W-1:0] first_idx;
    logic head_live;   // head cell holds a polygon vertex this step

    assign accept    = start && !busy;
    assign do_append = accept && (i_opcode == wn_pkg::OP_APPEND) && (r_count < NV);
    // vertices sit in the top r_count cells, oldest first, after appends
    assign first_idx = NV - r_count;
    assign head_live = (r_state == wn_pkg::ST_ROTATE) && (r_step >= first_idx);

    // ------------------------------------------------------------------
    // Vertex ring: cell k takes cell k+1; the tail takes either the new
    // vertex (append) or the head (rotation during a query).
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] c_x [MAX_VERTICES];
    logic [COORD_BITS-1:0] c_y [MAX_VERTICES];

    assign ring_shift = do_append || (r_state == wn_pkg::ST_ROTATE);

    generate
        for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
            if (k == MAX_VERTICES - 1) begin : g_tail
                wn_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                    .i_clk   (i_clk),
                    .i_shift (ring_shift),
                    .i_x     ((r_state == wn_pkg::ST_ROTATE) ? c_x[0] : d_cx),
                    .i_y     ((r_state == wn_pkg::ST_ROTATE) ? c_y[0] : d_cy),
                    .o_x     (c_x[k]),
                    .o_y     (c_y[k])
                );
            end else begin : g_body
                wn_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                    .i_clk   (i_clk),
                    .i_shift (ring_shift),
                    .i_x     (c_x[k+1]),
                    .i_y     (c_y[k+1]),
                    .o_x     (c_x[k]),
                    .o_y     (c_y[k])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Edge unit: edge (prev -> head) while rotating, (last -> first) at close
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] wn_sum;

    wn_edge_unit #(
        .COORD_BITS (COORD_BITS),
        .ACC_W      (ACC_W)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (edge_ctl),
        .i_ax    (r_prev_x),
        .i_ay    (r_prev_y),
        .i_bx    ((r_state == wn_pkg::ST_CLOSE) ? r_first_x : c_x[0]),
        .i_by    ((r_state == wn_pkg::ST_CLOSE) ? r_first_y : c_y[0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_wn    (wn_sum)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_step         = r_step;
        n_drain        = r_drain;
        n_valid        = 1'b0;
        busy           = (r_state != wn_pkg::ST_IDLE);
        edge_ctl.issue = 1'b0;
        edge_ctl.clear = 1'b0;
        case (r_state)
            wn_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        wn_pkg::OP_CLEAR: n_count = '0;
                        wn_pkg::OP_APPEND: begin
                            if (do_append) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        wn_pkg::OP_QUERY: begin
                            edge_ctl.clear = 1'b1;
                            n_step         = '0;
                            n_state        = wn_pkg::ST_ROTATE;
                        end
                        default: ;   // unused opcode: ignored
                    endcase
                end
            end
            wn_pkg::ST_ROTATE: begin
                // the first live head only seeds prev/first
                edge_ctl.issue = head_live && (r_step != first_idx);
                n_step         = r_step + CNT_W'(1);
                if (r_step == NV - CNT_W'(1)) begin
                    n_state = wn_pkg::ST_CLOSE;
                end
            end
            wn_pkg::ST_CLOSE: begin
                edge_ctl.issue = (r_count != '0);
                n_drain        = '0;
                n_state        = wn_pkg::ST_DRAIN;
            end
            wn_pkg::ST_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'(wn_pkg::PIPE_DEPTH - 1)) begin
                    n_valid = 1'b1;
                    n_state = wn_pkg::ST_IDLE;
                end
            end
            default: n_state = wn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wn_pkg::ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_drain <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_drain <= n_drain;
            r_valid <= n_valid;
        end
    end

    // Datapath registers (no reset needed)
    logic signed [SAT_W-1:0] wn_ext;
    assign wn_ext = SAT_W'(wn_sum);

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == wn_pkg::OP_QUERY)) begin
            r_px <= d_cx;
            r_py <= d_cy;
        end
        if (head_live) begin
            r_prev_x <= c_x[0];
            r_prev_y <= c_y[0];
            if (r_step == first_idx) begin
                r_first_x <= c_x[0];
                r_first_y <= c_y[0];
            end
        end
        if (n_valid) begin
            r_inside <= (wn_sum != '0);
            // saturate the reported count; inside uses the true count
            if (wn_ext > SAT_W'(wn_pkg::WINDING_MAX)) begin
                r_winding <= wn_pkg::WINDING_W'(wn_pkg::WINDING_MAX);
            end else if (wn_ext < -SAT_W'(wn_pkg::WINDING_MAX)) begin
                r_winding <= -wn_pkg::WINDING_W'(wn_pkg::WINDING_MAX);
            end else begin
                r_winding <= wn_ext[wn_pkg::WINDING_W-1:0];
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;
    assign o_winding    = r_winding;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NV)
        else $error("vertex count beyond capacity");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == wn_pkg::OP_QUERY)) |=> busy)
        else $error("query accepted but unit not busy");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == wn_pkg::ST_DRAIN))
        else $error("result strobe without a finished query");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_no_shift_when_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wn_pkg::ST_CLOSE || r_state == wn_pkg::ST_DRAIN) |-> !ring_shift)
        else $error("ring moved outside a request");

endmodule

`default_nettype wire

@@ bench/winding_number_point_in_polygon_unit_tb.sv @@
// ----------------------------------------------------------------------------
// winding_number_point_in_polygon_unit_tb: self-checking bench for the unit
// Streams clear, append and query requests through the start/busy handshake.
// Sender bursts and gaps are random. Each query result is checked against a
// bench-side winding-number calculation over its own copy of the polygon.
// ----------------------------------------------------------------------------

module winding_number_point_in_polygon_unit_tb;

    localparam int MAX_VERTICES   = 64;
    localparam int COORD_BITS     = 16;
    localparam int ITEMS_TARGET   = 850;
    // a query occupies the unit for one full ring turn plus the edge unit drain; longest sender gap is 80
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = MAX_VERTICES + 10;

    // opcode 3 has no enum member; the unit must ignore it
    localparam logic [wn_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;

    typedef struct {
        logic [wn_pkg::OPCODE_W-1:0] op;
        logic signed [15:0]          x;
        logic signed [15:0]          y;
    } t_wn_request;

    typedef struct {
        logic                                in_poly;
        logic signed [wn_pkg::WINDING_W-1:0] winding;
    } t_wn_answer;

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic                                i_clk     = 1'b0;
    logic                                i_rst_n   = 1'b0;
    logic                                start     = 1'b0;
    logic                                busy;
    logic [wn_pkg::OPCODE_W-1:0]         i_opcode  = '0;
    logic signed [15:0]                  i_coord_x = '0;
    logic signed [15:0]                  i_coord_y = '0;
    logic                                o_valid;
    logic                                o_inside_res;
    logic signed [wn_pkg::WINDING_W-1:0] o_winding;

    winding_number_point_in_polygon_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .o_valid     (o_valid),
        .o_inside_res(o_inside_res),
        .o_winding   (o_winding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_wn_request        pending_requests[$];   // filled up front, drained by driver
    t_wn_answer         expected_answers[$];   // one per accepted query, in order
    t_wn_request        in_flight;             // request currently on the ports

    // bench copy of the polygon store
    logic signed [15:0] poly_x[MAX_VERTICES];
    logic signed [15:0] poly_y[MAX_VERTICES];
    int                 poly_count = 0;

    int                 n_planned      = 0;
    int                 n_accepted     = 0;
    int                 n_checked      = 0;
    int                 n_inside       = 0;
    int                 n_dropped      = 0;
    int                 max_abs_wind   = 0;
    int                 errors         = 0;
    int                 gap_left       = 0;
    int                 burst_left     = 1;
    int                 idle_cycles    = 0;

    // ------------------------------------------------------------------
    // Winding number of the stored polygon around (px, py).
    // Exact cross product in 64 bits; upward crossing with the point
    // strictly left adds one, downward with it strictly right subtracts.
    // ------------------------------------------------------------------
    function automatic t_wn_answer winding_of_point(input logic signed [15:0] px,
                                                    input logic signed [15:0] py);
        longint     ax, ay, bx, by, cross_z;
        int         wn, nxt, sat;
        t_wn_answer ans;
        wn = 0;
        for (int i = 0; i < poly_count; i++) begin
            nxt     = (i + 1 < poly_count) ? i + 1 : 0;
            ax      = longint'(poly_x[i]) - longint'(px);
            ay      = longint'(poly_y[i]) - longint'(py);
            bx      = longint'(poly_x[nxt]) - longint'(px);
            by      = longint'(poly_y[nxt]) - longint'(py);
            cross_z = ax * by - ay * bx;
            if (ay <= 0) begin
                if (by > 0 && cross_z > 0) wn++;
            end else begin
                if (by <= 0 && cross_z < 0) wn--;
            end
        end
        // field saturates, flag follows the true count
        sat = wn;
        if (sat > wn_pkg::WINDING_MAX)  sat = wn_pkg::WINDING_MAX;
        if (sat < -wn_pkg::WINDING_MAX) sat = -wn_pkg::WINDING_MAX;
        ans.in_poly = (wn != 0);
        ans.winding = sat[wn_pkg::WINDING_W-1:0];
        return ans;
    endfunction

    // apply one accepted request to the bench polygon; queries queue an answer
    task automatic apply_request(input t_wn_request req);
        t_wn_answer ans;
        n_accepted++;
        case (req.op)
            wn_pkg::OP_CLEAR:  poly_count = 0;
            wn_pkg::OP_APPEND: begin
                if (poly_count < MAX_VERTICES) begin
                    poly_x[poly_count] = req.x;
                    poly_y[poly_count] = req.y;
                    poly_count++;
                end else begin
                    n_dropped++;
                end
            end
            wn_pkg::OP_QUERY: begin
                ans = winding_of_point(req.x, req.y);
                expected_answers.push_back(ans);
            end
            default: ;  // reserved opcode: no effect
        endcase
    endtask

    task automatic add_request(input logic [wn_pkg::OPCODE_W-1:0] op, input int x,
                               input int y);
        t_wn_request req;
        req.op = op;
        req.x  = x[15:0];
        req.y  = y[15:0];
        pending_requests.push_back(req);
        if (op != OP_RESERVED) n_planned++;
    endtask

    // ------------------------------------------------------------------
    // Driver: a request is taken at an edge with start high and busy low.
    // The slot is free when start is low or the current request was just
    // taken; only then do we pick the next one or insert a gap.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) apply_request(in_flight);
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_requests.size() > 0) begin
                in_flight  = pending_requests.pop_front();
                i_opcode  <= in_flight.op;
                i_coord_x <= in_flight.x;
                i_coord_y <= in_flight.y;
                start     <= 1'b1;
                // end of burst: mostly short gaps, some long ones so the
                // unit fully drains, some none at all
                if (burst_left <= 1) begin
                    case ($urandom_range(0, 5))
                        0, 1:    gap_left <= 0;
                        5:       gap_left <= $urandom_range(20, 80);
                        default: gap_left <= $urandom_range(1, 8);
                    endcase
                    burst_left <= $urandom_range(1, 24);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe is compared with the oldest pending answer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_wn_answer exp_ans;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result with no query pending: inside %0b winding %0d",
                         $time, o_inside_res, o_winding);
                errors++;
            end else begin
                exp_ans = expected_answers.pop_front();
                n_checked++;
                if (exp_ans.in_poly) n_inside++;
                if (exp_ans.winding > max_abs_wind) max_abs_wind = exp_ans.winding;
                if (-exp_ans.winding > max_abs_wind) max_abs_wind = -exp_ans.winding;
                if (o_inside_res !== exp_ans.in_poly) begin
                    $display("%0t: inside mismatch: expected %0b got %0b",
                             $time, exp_ans.in_poly, o_inside_res);
                    errors++;
                end
                if (o_winding !== exp_ans.winding) begin
                    $display("%0t: winding mismatch: expected %0d got %0d",
                             $time, exp_ans.winding, o_winding);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request taken nor a result strobed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
                $display("[winding_number_point_in_polygon_unit] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int  kind, nv, nq, turns, cx, cy, quad, sx, sy, mode, k, vi;
        bit  cw;
        int  gx[$];
        int  gy[$];

        // directed: empty polygon, single vertex, extreme CCW square with
        // boundary points, reserved opcode, small CW square
        add_request(wn_pkg::OP_QUERY, 0, 0);
        add_request(wn_pkg::OP_QUERY, -32768, 32767);
        add_request(wn_pkg::OP_APPEND, 5, 5);
        add_request(wn_pkg::OP_QUERY, 0, 0);
        add_request(wn_pkg::OP_QUERY, 5, 5);
        add_request(wn_pkg::OP_CLEAR, -1, -1);
        add_request(wn_pkg::OP_APPEND, -32768, -32768);
        add_request(wn_pkg::OP_APPEND, 32767, -32768);
        add_request(wn_pkg::OP_APPEND, 32767, 32767);
        add_request(wn_pkg::OP_APPEND, -32768, 32767);
        add_request(wn_pkg::OP_QUERY, 0, 0);
        add_request(wn_pkg::OP_QUERY, -32768, -32768);
        add_request(wn_pkg::OP_QUERY, 32767, 0);
        add_request(wn_pkg::OP_QUERY, -32768, 0);
        add_request(OP_RESERVED, 32767, -1);
        add_request(wn_pkg::OP_QUERY, 0, 32767);
        add_request(wn_pkg::OP_CLEAR, 0, 0);
        add_request(wn_pkg::OP_APPEND, 10, 10);
        add_request(wn_pkg::OP_APPEND, 10, -10);
        add_request(wn_pkg::OP_APPEND, -10, -10);
        add_request(wn_pkg::OP_APPEND, -10, 10);
        add_request(wn_pkg::OP_QUERY, 0, 0);
        add_request(wn_pkg::OP_QUERY, 0, 10);
        add_request(wn_pkg::OP_QUERY, 0, -10);
        add_request(wn_pkg::OP_QUERY, 20, 0);

        // random groups: clear, build a polygon, query it
        while (n_planned < ITEMS_TARGET) begin
            kind = $urandom_range(0, 19);
            gx.delete();
            gy.delete();
            cx = 0;
            cy = 0;
            // occasionally keep the old polygon and keep appending
            if ($urandom_range(0, 7) != 0)
                add_request(wn_pkg::OP_CLEAR, $urandom_range(0, 65535),
                            $urandom_range(0, 65535));
            if (kind < 8) begin
                // tight box: many ties on vertex heights and collinear points
                nv = $urandom_range(1, 10);
                for (k = 0; k < nv; k++) begin
                    gx.push_back(int'($urandom_range(0, 16)) - 8);
                    gy.push_back(int'($urandom_range(0, 16)) - 8);
                end
            end else if (kind < 14) begin
                // star wrapping the center several times, either direction
                turns = $urandom_range(1, 4);
                cw    = 1'($urandom_range(0, 1));
                cx    = int'($urandom_range(0, 2000)) - 1000;
                cy    = int'($urandom_range(0, 2000)) - 1000;
                for (k = 0; k < 4 * turns; k++) begin
                    quad = cw ? 3 - (k % 4) : k % 4;
                    sx   = (quad == 0 || quad == 3) ? 1 : -1;
                    sy   = (quad < 2) ? 1 : -1;
                    gx.push_back(cx + sx * int'($urandom_range(1, 20000)));
                    gy.push_back(cy + sy * int'($urandom_range(1, 20000)));
                end
            end else if (kind < 17) begin
                nv = $urandom_range(3, 12);
                for (k = 0; k < nv; k++) begin
                    gx.push_back(int'($urandom_range(0, 65535)) - 32768);
                    gy.push_back(int'($urandom_range(0, 65535)) - 32768);
                end
            end else if (kind < 18) begin
                // run near or past capacity; extra appends are dropped
                nv = $urandom_range(60, 70);
                for (k = 0; k < nv; k++) begin
                    gx.push_back(int'($urandom_range(0, 8000)) - 4000);
                    gy.push_back(int'($urandom_range(0, 8000)) - 4000);
                end
            end else begin
                // noise, reserved opcode included
                nv = $urandom_range(1, 6);
                for (k = 0; k < nv; k++)
                    add_request(wn_pkg::OPCODE_W'($urandom_range(0, 3)),
                                $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            for (k = 0; k < gx.size(); k++)
                add_request(wn_pkg::OP_APPEND, gx[k], gy[k]);

            nq = $urandom_range(1, 6);
            for (k = 0; k < nq; k++) begin
                mode = $urandom_range(0, 4);
                vi   = (gx.size() > 0) ? $urandom_range(0, gx.size() - 1) : 0;
                if (gx.size() == 0 && mode < 2) mode = 2;
                case (mode)
                    0: add_request(wn_pkg::OP_QUERY, gx[vi], gy[vi]);
                    1: add_request(wn_pkg::OP_QUERY, gx[vi] + int'($urandom_range(0, 2)) - 1,
                                   gy[vi] + int'($urandom_range(0, 2)) - 1);
                    2: add_request(wn_pkg::OP_QUERY, cx + int'($urandom_range(0, 6)) - 3,
                                   cy + int'($urandom_range(0, 6)) - 3);
                    3: add_request(wn_pkg::OP_QUERY, $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
                    default: add_request(wn_pkg::OP_QUERY, int'($urandom_range(0, 20)) - 10,
                                         int'($urandom_range(0, 20)) - 10);
                endcase
            end
        end

        // reset held from time zero, then released once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the queue to drain and every answer to arrive
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || start || expected_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d query results checked, %0d inside, max |winding| %0d,",
                 n_accepted, n_checked, n_inside, max_abs_wind);
        $display("%0d appends dropped at a full store, %0d mismatches.", n_dropped, errors);
        if (errors == 0 && expected_answers.size() == 0)
            $display("[winding_number_point_in_polygon_unit] OK");
        else
            $display("[winding_number_point_in_polygon_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/wn_pkg.sv
rtl/wn_cell.sv
rtl/wn_edge_unit.sv
rtl/winding_number_point_in_polygon_unit.sv
bench/winding_number_point_in_polygon_unit_tb.sv
